>>> hdl/epm_pkg.sv
`default_nettype none

package epm_pkg;

  // Default build values for the top-level parameters
  localparam int unsigned EPM_MAX_PATTERN   = 32;
  localparam int unsigned EPM_POSITION_BITS = 32;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenCfgW  = 6;

  // Fixed pattern storage: four 64-bit words, 32 bytes
  localparam int unsigned PatWords = 4;
  localparam int unsigned PatBytes = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLength = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWord0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWord1  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWord2  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWord3  = 3'd4;

  // One text byte as held in the input stage
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  // One result as held in the output stage
  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
    logic [31:0] match_count;
    logic        text_done;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/epm_pattern.sv
`default_nettype none

module epm_pattern #(
  parameter int unsigned MAX_PATTERN = epm_pkg::EPM_MAX_PATTERN,
  parameter int unsigned LenW        = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [epm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [epm_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic      [LenW-1:0]               eff_len_o,
  output logic      [MAX_PATTERN-1:0][7:0]   aligned_o,
  output logic      [MAX_PATTERN-1:0]        care_o
);
  import epm_pkg::*;

  logic [LenCfgW-1:0]                len_cfg_q;
  logic [PatWords-1:0][CfgDataW-1:0] words_q;
  logic [PatBytes-1:0][7:0]          pat_bytes;

  logic [LenCfgW-1:0]           eff_len;
  logic [LenCfgW-1:0]           rel;
  logic [LenW-1:0]              eff_len_d, eff_len_q;
  logic [MAX_PATTERN-1:0][7:0]  aligned_d, aligned_q;
  logic [MAX_PATTERN-1:0]       care_d, care_q;

  // Decode register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LenCfgW'(2);
      words_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLength: len_cfg_q  <= cfg_data_i[LenCfgW-1:0];
        CfgWord0:  words_q[0] <= cfg_data_i;
        CfgWord1:  words_q[1] <= cfg_data_i;
        CfgWord2:  words_q[2] <= cfg_data_i;
        CfgWord3:  words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pat_bytes = words_q;

  // Clamp the length and line the pattern up with the window, newest byte at entry 0
  always_comb begin
    if (len_cfg_q < LenCfgW'(2)) begin
      eff_len = LenCfgW'(2);
    end else if (len_cfg_q > LenCfgW'(MAX_PATTERN)) begin
      eff_len = LenCfgW'(MAX_PATTERN);
    end else begin
      eff_len = len_cfg_q;
    end
    eff_len_d = LenW'(eff_len);
    rel       = '0;
    for (int w = 0; w < MAX_PATTERN; w++) begin
      rel = eff_len - LenCfgW'(w) - LenCfgW'(1);
      if (LenCfgW'(w) < eff_len) begin
        aligned_d[w] = pat_bytes[rel[4:0]];
        care_d[w]    = 1'b1;
      end else begin
        aligned_d[w] = '0;
        care_d[w]    = 1'b0;
      end
    end
  end

  // Hold the aligned pattern so the compare path stays short
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= LenW'(2);
      aligned_q <= '0;
      care_q    <= MAX_PATTERN'(2'b11);
    end else begin
      eff_len_q <= eff_len_d;
      aligned_q <= aligned_d;
      care_q    <= care_d;
    end
  end

  assign eff_len_o = eff_len_q;
  assign aligned_o = aligned_q;
  assign care_o    = care_q;

endmodule

`default_nettype wire

>>> hdl/epm_scan.sv
`default_nettype none

module epm_scan #(
  parameter int unsigned MAX_PATTERN   = epm_pkg::EPM_MAX_PATTERN,
  parameter int unsigned POSITION_BITS = epm_pkg::EPM_POSITION_BITS,
  parameter int unsigned LenW          = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire epm_pkg::item_t              item_i,
  input  wire logic [LenW-1:0]             eff_len_i,
  input  wire logic [MAX_PATTERN-1:0][7:0] aligned_i,
  input  wire logic [MAX_PATTERN-1:0]      care_i,
  output epm_pkg::result_t                 result_o
);
  import epm_pkg::*;

  localparam int unsigned StartW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  logic [MAX_PATTERN-1:0][7:0] window_d, window_q;
  logic [LenW-1:0]             seen_d, seen_q;
  logic [POSITION_BITS-1:0]    pos_q;
  logic [31:0]                 total_d, total_q;
  logic [MAX_PATTERN-1:0]      byte_ok;
  logic                        hit;
  logic [POSITION_BITS-1:0]    start_pos;
  logic [StartW-1:0]           start_wide;

  // Shift the new byte in and compare every window entry in parallel
  always_comb begin
    window_d[0] = item_i.text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_d[k] = window_q[k-1];
    end
    for (int w = 0; w < MAX_PATTERN; w++) begin
      byte_ok[w] = !care_i[w] || (window_d[w] == aligned_i[w]);
    end
  end

  assign seen_d = (seen_q < LenW'(MAX_PATTERN)) ? seen_q + LenW'(1) : seen_q;
  assign hit    = (&byte_ok) && (seen_d >= eff_len_i);

  // Start of the occurrence, wrapping with the position counter
  assign start_pos  = pos_q - POSITION_BITS'(eff_len_i) + POSITION_BITS'(1);
  assign start_wide = StartW'(start_pos);

  // Saturating match count
  assign total_d = (hit && (total_q != '1)) ? total_q + 32'd1 : total_q;

  assign result_o.match_found = hit;
  assign result_o.match_start = hit ? start_wide[31:0] : 32'd0;
  assign result_o.match_count = total_d;
  assign result_o.text_done   = item_i.end_of_text;

  // Advance the text state; clear it after the last byte of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      seen_q   <= '0;
      pos_q    <= '0;
      total_q  <= '0;
    end else if (advance_i) begin
      if (item_i.end_of_text) begin
        window_q <= '0;
        seen_q   <= '0;
        pos_q    <= '0;
        total_q  <= '0;
      end else begin
        window_q <= window_d;
        seen_q   <= seen_d;
        pos_q    <= pos_q + POSITION_BITS'(1);
        total_q  <= total_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/exact_pattern_matcher_core.sv
// Exact pattern matcher.
// Text enters on the slave stream one byte per transaction: tdata[7:0] is the
// byte, tlast marks the last byte of a text. Each byte yields exactly one
// result transaction on the master stream: tdata[31:0] is the start position
// of an occurrence that ends at this byte (zero when none), tdata[63:32] the
// saturating match count of the current text, tuser the match flag and tlast
// the end-of-text echo.
// The pattern (2 to MAX_PATTERN bytes) and its length are written through the
// configuration port; the user must write them only while no text byte is in
// flight, as the block does not enforce it. A byte accepted into the input
// register has its result formed by a single pass of parallel window compare
// and stored into the output register.
// Throughput is one byte per cycle while the receiver does not stall.
// The input stage keeps accepting while a result waits in the output
// register; a stall from the receiver backs up into s_axis_tready_o only once
// both stages hold a transaction.
// Reset clears the window, position, count and registers (length 2, pattern
// all zero); the text state also clears after every byte marked tlast.
`default_nettype none

module exact_pattern_matcher_core #(
  parameter int unsigned MAX_PATTERN   = epm_pkg::EPM_MAX_PATTERN,
  parameter int unsigned POSITION_BITS = epm_pkg::EPM_POSITION_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [epm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [epm_pkg::CfgDataW-1:0] cfg_data_i,
  // Text stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // text_byte
  input  wire logic                         s_axis_tlast_i,  // end_of_text
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic      [63:0]                  m_axis_tdata_o,  // match_start, match_count
  output logic                              m_axis_tuser_o,  // match_found
  output logic                              m_axis_tlast_o   // text_done
);
  import epm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic                        s_accept;
  logic                        advance;
  logic                        s1_valid_q;
  item_t                       s1_item_q;
  logic                        out_valid_q;
  result_t                     out_q;
  result_t                     result;
  logic [LenW-1:0]             eff_len;
  logic [MAX_PATTERN-1:0][7:0] aligned;
  logic [MAX_PATTERN-1:0]      care;

  epm_pattern #(
    .MAX_PATTERN(MAX_PATTERN),
    .LenW       (LenW)
  ) u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .eff_len_o  (eff_len),
    .aligned_o  (aligned),
    .care_o     (care)
  );

  epm_scan #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS),
    .LenW         (LenW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (s1_item_q),
    .eff_len_i(eff_len),
    .aligned_i(aligned),
    .care_i   (care),
    .result_o (result)
  );

  // Move the held byte forward whenever the output register is free or drains
  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_item_q.text_byte   <= s_axis_tdata_i;
      s1_item_q.end_of_text <= s_axis_tlast_i;
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.match_count, out_q.match_start};
  assign m_axis_tuser_o  = out_q.match_found;
  assign m_axis_tlast_o  = out_q.text_done;

`ifndef SYNTH
  // A flagged match always carries a nonzero count
  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.match_found) |-> (out_q.match_count != 32'd0))
    else $error("match flagged with zero count");

  // Start position is zero when no match is flagged
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.match_found) |-> (out_q.match_start == 32'd0))
    else $error("start position set without a match");

  // Both stages full under a stall must block the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted with both stages full");

  // A stalled held byte stays in the input stage
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input stage lost a stalled byte");
`endif

endmodule

`default_nettype wire
